// ===== src/qalu_pkg.sv =====
// Shared types, operation codes and helpers for the quaternion ALU.
package qalu_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // quotient bits produced by the divider, one per step
    localparam int QB    = 33;
    // partial remainder and numerator magnitude width
    localparam int REM_W = 66;
    // sum of squares of b
    localparam int DEN_W = 65;

    // b component used by product i of result row k
    localparam logic [1:0] MUL_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    // bit i set: product i of row k is subtracted
    localparam logic [3:0] MUL_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};
    localparam logic [3:0] DIV_NEG [4] = '{4'b0000, 4'b0101, 4'b1001, 4'b0011};

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_w;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic               overflow;
        logic               divide_by_zero;
    } rsp_t;

    // item moving through the divider steps
    typedef struct packed {
        logic                       is_div;
        logic                       dz;
        logic [3:0]                 neg;
        logic [3:0]                 hi;
        logic [3:0][REM_W-1:0]      rem;
        logic [3:0][QB-1:0]         low;
        logic [DEN_W-1:0]           den;
        logic [3:0][31:0]           res;
        logic                       ovf;
    } div_item_t;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } sat_t;

    function automatic sat_t sat66(input logic signed [REM_W-1:0] v,
                                   input int unsigned satw);
        logic signed [REM_W-1:0] hi_lim;
        logic signed [REM_W-1:0] lo_lim;
        sat_t r;
        hi_lim = (66'sd1 <<< (satw - 1)) - 66'sd1;
        lo_lim = -hi_lim - 66'sd1;
        if (v > hi_lim)
        begin
            r.val = hi_lim[31:0];
            r.ovf = 1'b1;
        end
        else if (v < lo_lim)
        begin
            r.val = lo_lim[31:0];
            r.ovf = 1'b1;
        end
        else
        begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/qalu_div_step.sv =====
// One restoring-division step for four quotient lanes, with its own pipeline register.
module qalu_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  qalu_pkg::div_item_t up,
    output logic                dn_valid,
    input  logic                dn_ready,
    output qalu_pkg::div_item_t dn
);

    logic                valid_reg;
    qalu_pkg::div_item_t item_reg;
    qalu_pkg::div_item_t item_next;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = item_reg;

    always_comb
    begin
        logic [qalu_pkg::REM_W-1:0] r2;
        logic [qalu_pkg::REM_W-1:0] d;
        logic                       qbit;
        item_next = up;
        d = {1'b0, up.den};
        for (int k = 0; k < 4; k++)
        begin
            r2   = {up.rem[k][qalu_pkg::REM_W-2:0], up.low[k][qalu_pkg::QB-1]};
            qbit = (r2 >= d);
            item_next.rem[k] = qbit ? (r2 - d) : r2;
            item_next.low[k] = {up.low[k][qalu_pkg::QB-2:0], qbit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== src/quaternion_alu.sv =====
// Quaternion ALU top level: product, sum, setup and output stages around the divider chain.

// Pipelined quaternion ALU: add, subtract, Hamilton product and a*conj(b)/|b|^2
// on signed fixed-point components, saturated to DATA_WIDTH (at most 32) bits.
// One request is taken every cycle while req_stall is low. Each result passes
// through one stage of 20 multipliers, one of product sums, one of scaling and
// divider setup, 33 restoring-division steps (one quotient bit per stage, four
// lanes) and the output register. All ops take the same path, so results leave
// in request order. Divide by a zero b returns zero with divide_by_zero set.
// The stall path runs combinationally back through the stage chain, so empty
// stages keep filling while the output waits.
module quaternion_alu #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  qalu_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output qalu_pkg::rsp_t rsp
);

    localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int NW    = qalu_pkg::REM_W + FRACTION_BITS;
    localparam int QB    = qalu_pkg::QB;

    // ---------------- stage 1: products ----------------
    logic                     s1_v_reg;
    logic [1:0]               s1_op_reg;
    logic signed [63:0]       s1_prod_reg [4][4];
    logic signed [63:0]       s1_prod_next [4][4];
    logic signed [63:0]       s1_sq_reg [4];
    logic signed [63:0]       s1_sq_next [4];
    logic signed [32:0]       s1_as_reg [4];
    logic signed [32:0]       s1_as_next [4];
    logic                     s1_adv;

    // ---------------- stage 2: sums ----------------
    logic                     s2_v_reg;
    logic [1:0]               s2_op_reg;
    logic signed [qalu_pkg::REM_W-1:0] s2_num_reg [4];
    logic signed [qalu_pkg::REM_W-1:0] s2_num_next [4];
    logic [qalu_pkg::DEN_W-1:0]        s2_den_reg;
    logic [qalu_pkg::DEN_W-1:0]        s2_den_next;
    logic                     s2_adv;

    // ---------------- stage 3: scale and divider setup ----------------
    logic                     s3_v_reg;
    qalu_pkg::div_item_t      s3_reg;
    qalu_pkg::div_item_t      s3_next;
    logic                     s3_adv;

    // ---------------- divider chain and output ----------------
    logic                     dv   [QB+1];
    logic                     drdy [QB+1];
    qalu_pkg::div_item_t      ditem [QB+1];
    logic                     rsp_v_reg;
    qalu_pkg::rsp_t           rsp_reg;
    qalu_pkg::rsp_t           rsp_next;
    logic                     out_adv;

    logic signed [31:0] av [4];
    logic signed [31:0] bv [4];

    assign av[0] = req.a_w;
    assign av[1] = req.a_x;
    assign av[2] = req.a_y;
    assign av[3] = req.a_z;
    assign bv[0] = req.b_w;
    assign bv[1] = req.b_x;
    assign bv[2] = req.b_y;
    assign bv[3] = req.b_z;

    assign out_adv   = !rsp_v_reg || !rsp_stall;
    assign s3_adv    = !s3_v_reg || drdy[0];
    assign s2_adv    = !s2_v_reg || s3_adv;
    assign s1_adv    = !s1_v_reg || s2_adv;
    assign req_stall = !s1_adv;
    assign rsp_valid = rsp_v_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s1_prod_next[k][i] = 64'(av[i]) * 64'(bv[qalu_pkg::MUL_B[k][i]]);
            end
            s1_sq_next[k] = 64'(bv[k]) * 64'(bv[k]);
            s1_as_next[k] = (req.req_type == qalu_pkg::OP_SUB)
                          ? (33'(av[k]) - 33'(bv[k])) : (33'(av[k]) + 33'(bv[k]));
        end
    end

    always_comb
    begin
        logic [3:0]                        negm;
        logic signed [qalu_pkg::REM_W-1:0] acc;
        logic signed [qalu_pkg::REM_W-1:0] t;
        s2_den_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            s2_den_next = s2_den_next + qalu_pkg::DEN_W'(s1_sq_reg[i][62:0]);
        end
        for (int k = 0; k < 4; k++)
        begin
            negm = (s1_op_reg == qalu_pkg::OP_DIV) ? qalu_pkg::DIV_NEG[k]
                                                   : qalu_pkg::MUL_NEG[k];
            acc = '0;
            for (int i = 0; i < 4; i++)
            begin
                t   = qalu_pkg::REM_W'(s1_prod_reg[k][i]);
                acc = negm[i] ? (acc - t) : (acc + t);
            end
            // add/sub results ride in the same slot
            if (s1_op_reg == qalu_pkg::OP_ADD || s1_op_reg == qalu_pkg::OP_SUB)
            begin
                s2_num_next[k] = qalu_pkg::REM_W'(s1_as_reg[k]);
            end
            else
            begin
                s2_num_next[k] = acc;
            end
        end
    end

    always_comb
    begin
        logic signed [qalu_pkg::REM_W-1:0] shr;
        logic [qalu_pkg::REM_W-1:0]        absn;
        logic [NW-1:0]                     sh;
        qalu_pkg::sat_t                    s;
        s3_next        = '0;
        s3_next.den    = s2_den_reg;
        s3_next.is_div = (s2_op_reg == qalu_pkg::OP_DIV);
        s3_next.dz     = s3_next.is_div && (s2_den_reg == '0);
        for (int k = 0; k < 4; k++)
        begin
            shr = (s2_op_reg == qalu_pkg::OP_MUL) ? (s2_num_reg[k] >>> FRACTION_BITS)
                                                  : s2_num_reg[k];
            s = qalu_pkg::sat66(shr, SAT_W);
            s3_next.neg[k] = s2_num_reg[k][qalu_pkg::REM_W-1];
            absn = s3_next.neg[k] ? qalu_pkg::REM_W'(-s2_num_reg[k])
                                  : qalu_pkg::REM_W'(s2_num_reg[k]);
            sh = NW'(absn) << FRACTION_BITS;
            s3_next.rem[k] = qalu_pkg::REM_W'(sh >> QB);
            s3_next.low[k] = sh[QB-1:0];
            // quotient would not fit in the step count
            s3_next.hi[k]  = (s3_next.rem[k] >= {1'b0, s2_den_reg});
            if (!s3_next.is_div)
            begin
                s3_next.res[k] = s.val;
                s3_next.ovf    = s3_next.ovf | s.ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            rsp_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_v_reg <= req_valid;
            end
            if (s2_adv)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_adv)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (out_adv)
            begin
                rsp_v_reg <= dv[QB];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && req_valid)
        begin
            s1_op_reg   <= req.req_type;
            s1_prod_reg <= s1_prod_next;
            s1_sq_reg   <= s1_sq_next;
            s1_as_reg   <= s1_as_next;
        end
        if (s2_adv && s1_v_reg)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_num_reg <= s2_num_next;
            s2_den_reg <= s2_den_next;
        end
        if (s3_adv && s2_v_reg)
        begin
            s3_reg <= s3_next;
        end
        if (out_adv && dv[QB])
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign dv[0]    = s3_v_reg;
    assign ditem[0] = s3_reg;
    assign drdy[QB] = out_adv;

    for (genvar g = 0; g < QB; g++)
    begin : g_div
        qalu_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (dv[g]),
            .up_ready (drdy[g]),
            .up       (ditem[g]),
            .dn_valid (dv[g+1]),
            .dn_ready (drdy[g+1]),
            .dn       (ditem[g+1])
        );
    end

    always_comb
    begin
        qalu_pkg::div_item_t d;
        logic [QB-1:0]       lim;
        logic [QB-1:0]       mag;
        logic [31:0]         val [4];
        logic                ovf;
        d   = ditem[QB];
        lim = (QB'(1) << (SAT_W - 1)) - QB'(1);
        ovf = d.ovf;
        for (int k = 0; k < 4; k++)
        begin
            mag    = d.low[k];
            val[k] = d.res[k];
            if (d.is_div)
            begin
                if (d.dz)
                begin
                    val[k] = '0;
                end
                else if (!d.neg[k] && (d.hi[k] || mag > lim))
                begin
                    val[k] = lim[31:0];
                    ovf    = 1'b1;
                end
                else if (d.neg[k] && (d.hi[k] || mag > lim + QB'(1)))
                begin
                    val[k] = ~lim[31:0];
                    ovf    = 1'b1;
                end
                else
                begin
                    val[k] = d.neg[k] ? (~mag[31:0] + 32'd1) : mag[31:0];
                end
            end
        end
        rsp_next.res_w          = val[0];
        rsp_next.res_x          = val[1];
        rsp_next.res_y          = val[2];
        rsp_next.res_z          = val[3];
        rsp_next.overflow       = ovf && !d.dz;
        rsp_next.divide_by_zero = d.dz;
    end

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.divide_by_zero |->
            rsp.res_w == 0 && rsp.res_x == 0 && rsp.res_y == 0 && rsp.res_z == 0
            && !rsp.overflow)
        else $error("divide by zero result not cleared");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_v_reg |-> !req_stall)
        else $error("empty front stage stalls requests");

    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_v_reg && dv[QB] |=> rsp_v_reg)
        else $error("finished item not moved to output");

endmodule
